// ===== hw/rtl/lru_worker_dispatch_queues_assert.svh =====
// Assertion macros for the worker dispatcher.
// Used by the top level only; no other dependencies.
`ifndef LRU_WORKER_DISPATCH_QUEUES_ASSERT_SVH
`define LRU_WORKER_DISPATCH_QUEUES_ASSERT_SVH

// Same-cycle implication.
`define LWDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lwdq: same-cycle check failed");

// Next-cycle implication.
`define LWDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lwdq: next-cycle check failed");

`endif

// ===== hw/rtl/lwdq_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the worker dispatcher. No dependencies.
`timescale 1ns / 1ps

package lwdq_pkg;

   localparam int LWDQ_MAX_WORKERS     = 8;
   localparam int LWDQ_QUEUE_DEPTH     = 16;
   localparam int LWDQ_REQUEST_ID_BITS = 16;

   localparam int OP_W   = 3;
   localparam int SLOT_W = 3;
   localparam int REQ_W  = 16;
   localparam int MASK_W = 8;
   localparam int STAT_W = 3;
   localparam int QTOT_W = 8;

   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_TERMINATE = 3'd1;
   localparam logic [OP_W-1:0] OP_ENQUEUE   = 3'd2;
   localparam logic [OP_W-1:0] OP_FINISHED  = 3'd3;
   localparam logic [OP_W-1:0] OP_ASSIGN    = 3'd4;
   localparam logic [OP_W-1:0] OP_CANCEL    = 3'd5;
   localparam logic [OP_W-1:0] OP_QUERY     = 3'd6;

   localparam logic [STAT_W-1:0] ST_ASSIGNED = 3'd0;
   localparam logic [STAT_W-1:0] ST_QUEUED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_ELIG  = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd4;

   // where the request field of a result comes from
   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_REQ,
      SRC_CUR,
      SRC_RAM
   } emit_src_type;

   typedef struct packed {
      logic              capture;
      logic              idx_clr;
      logic              idx_inc;
      logic              hit_latch;
      logic              join_slot;
      logic              enq_assign;
      logic              enq_queue;
      logic              term_start;
      logic              term_close;
      logic              pop_issue;
      logic              pop_dec_total;
      logic              pop_to_current;
      logic              clear_busy;
      logic              emit;
      logic [STAT_W-1:0] emit_status;
      emit_src_type      emit_src;
      logic              emit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            slot_in_range;
      logic            slot_act;
      logic            tgt_busy;
      logic            tgt_empty;
      logic            tgt_full;
      logic            scan_end;
      logic            scan_hit;
   } dp_stat_type;

endpackage

// ===== hw/rtl/lwdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lwdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lwdq_ctrl.sv =====
// Sequencing state machine of the worker dispatcher.
// Depends on lwdq_pkg; drives lwdq_dpath through dp_cmd_type.
`timescale 1ns / 1ps

module lwdq_ctrl
   import lwdq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_ENQ      = 3'd3;
   localparam logic [2:0] S_TERM     = 3'd4;
   localparam logic [2:0] S_POP_WB   = 3'd5;
   localparam logic [2:0] S_T_RD     = 3'd6;
   localparam logic [2:0] S_T_OUT    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // single-result default; overridden below
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_NOTHING;
            cmd.emit_src    = SRC_NONE;
            cmd.emit_last   = 1'b1;
            state_in        = S_IDLE;
            case (stat.op)
               OP_ADD: begin
                  cmd.join_slot = stat.slot_in_range && !stat.slot_act;
               end
               OP_TERMINATE: begin
                  if (stat.slot_act) begin
                     cmd.emit       = 1'b0;
                     cmd.term_start = 1'b1;
                     cmd.idx_clr    = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               OP_ENQUEUE: begin
                  cmd.emit    = 1'b0;
                  cmd.idx_clr = 1'b1;
                  state_in    = S_SCAN;
               end
               OP_FINISHED, OP_ASSIGN: begin
                  if (stat.slot_act) begin
                     cmd.clear_busy = (stat.op == OP_FINISHED);
                     if (!stat.tgt_empty) begin
                        cmd.emit          = 1'b0;
                        cmd.pop_issue     = 1'b1;
                        cmd.pop_dec_total = 1'b1;
                        state_in          = S_POP_WB;
                     end
                  end
               end
               OP_CANCEL, OP_QUERY: begin
                  if (stat.slot_act && stat.tgt_busy) begin
                     cmd.emit_status = ST_ASSIGNED;
                     cmd.emit_src    = SRC_CUR;
                     cmd.clear_busy  = (stat.op == OP_CANCEL);
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = (stat.op == OP_ENQUEUE) ? ST_NO_ELIG : ST_NOTHING;
               cmd.emit_src    = SRC_NONE;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end else if (stat.scan_hit) begin
               cmd.hit_latch = 1'b1;
               state_in      = (stat.op == OP_ENQUEUE) ? S_ENQ : S_TERM;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_ENQ: begin
            cmd.emit      = 1'b1;
            cmd.emit_src  = SRC_REQ;
            cmd.emit_last = 1'b1;
            if (!stat.tgt_busy) begin
               cmd.enq_assign  = 1'b1;
               cmd.emit_status = ST_ASSIGNED;
            end else if (stat.tgt_full) begin
               cmd.emit_status = ST_FULL;
            end else begin
               cmd.enq_queue   = 1'b1;
               cmd.emit_status = ST_QUEUED;
            end
            state_in = S_IDLE;
         end
         S_TERM: begin
            cmd.term_close = 1'b1;
            if (stat.tgt_busy) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_ASSIGNED;
               cmd.emit_src    = SRC_CUR;
               cmd.emit_last   = stat.tgt_empty;
            end else if (stat.tgt_empty) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = ST_NOTHING;
               cmd.emit_src    = SRC_NONE;
               cmd.emit_last   = 1'b1;
            end
            state_in = stat.tgt_empty ? S_IDLE : S_T_RD;
         end
         S_T_RD: begin
            cmd.pop_issue = 1'b1;
            state_in      = S_T_OUT;
         end
         S_T_OUT: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_ASSIGNED;
            cmd.emit_src    = SRC_RAM;
            cmd.emit_last   = stat.tgt_empty;
            state_in        = stat.tgt_empty ? S_IDLE : S_T_RD;
         end
         S_POP_WB: begin
            cmd.pop_to_current = 1'b1;
            cmd.emit           = 1'b1;
            cmd.emit_status    = ST_ASSIGNED;
            cmd.emit_src       = SRC_RAM;
            cmd.emit_last      = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/lwdq_dpath.sv =====
// Datapath of the worker dispatcher: service list, worker flags,
// FIFO pointers, pending-request RAM and result register.
// Depends on lwdq_pkg and lwdq_ram.
`timescale 1ns / 1ps

module lwdq_dpath
   import lwdq_pkg::*;
#(
   parameter int MAX_WORKERS     = LWDQ_MAX_WORKERS,
   parameter int QUEUE_DEPTH     = LWDQ_QUEUE_DEPTH,
   parameter int REQUEST_ID_BITS = LWDQ_REQUEST_ID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [SLOT_W-1:0] req_worker_slot,
   input  logic [REQ_W-1:0]  req_request_id,
   input  logic              req_request_valid,
   input  logic [MASK_W-1:0] req_eligible_mask,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   output logic              rsp_strobe,
   output logic [STAT_W-1:0] rsp_status,
   output logic [SLOT_W-1:0] rsp_chosen_worker,
   output logic [REQ_W-1:0]  rsp_out_request,
   output logic              rsp_out_valid,
   output logic              rsp_last,
   output logic [QTOT_W-1:0] rsp_queued_total
);

   localparam int SW = $clog2(MAX_WORKERS);
   localparam int CW = $clog2(MAX_WORKERS + 1);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int RAM_DEPTH = MAX_WORKERS * QUEUE_DEPTH;
   localparam int AW = $clog2(RAM_DEPTH);
   localparam int TW = $clog2(RAM_DEPTH + 1);
   localparam int RB = REQUEST_ID_BITS;

   // captured item
   logic [OP_W-1:0]   cap_op_ff,    cap_op_in;
   logic [SLOT_W-1:0] cap_slot_ff,  cap_slot_in;
   logic [RB-1:0]     cap_req_ff,   cap_req_in;
   logic              cap_rvalid_ff, cap_rvalid_in;
   logic [MASK_W-1:0] cap_mask_ff,  cap_mask_in;

   // scan state
   logic [CW-1:0] idx_ff,     idx_in;
   logic [SW-1:0] hit_c_ff,   hit_c_in;
   logic [SW-1:0] hit_pos_ff, hit_pos_in;

   // worker state
   logic [SW-1:0] order_ff  [MAX_WORKERS];
   logic [SW-1:0] order_in  [MAX_WORKERS];
   logic [CW-1:0] count_ff, count_in;
   logic          active_ff [MAX_WORKERS];
   logic          active_in [MAX_WORKERS];
   logic          wbusy_ff  [MAX_WORKERS];
   logic          wbusy_in  [MAX_WORKERS];
   logic [RB-1:0] cur_ff    [MAX_WORKERS];
   logic [RB-1:0] cur_in    [MAX_WORKERS];
   logic [PW-1:0] head_ff   [MAX_WORKERS];
   logic [PW-1:0] head_in   [MAX_WORKERS];
   logic [PW-1:0] tail_ff   [MAX_WORKERS];
   logic [PW-1:0] tail_in   [MAX_WORKERS];
   logic [FW-1:0] fill_ff   [MAX_WORKERS];
   logic [FW-1:0] fill_in   [MAX_WORKERS];
   logic [TW-1:0] total_ff, total_in;

   // result register
   logic              strobe_ff,  strobe_in;
   logic [STAT_W-1:0] status_ff,  status_in;
   logic [SLOT_W-1:0] chosen_ff,  chosen_in;
   logic [REQ_W-1:0]  oreq_ff,    oreq_in;
   logic              ovalid_ff,  ovalid_in;
   logic              last_ff,    last_in;
   logic [QTOT_W-1:0] qtot_ff,    qtot_in;

   logic [MAX_WORKERS-1:0] mask_ext;
   logic [SW-1:0]          w;
   logic [SW-1:0]          tgt;
   logic [SW-1:0]          scan_ent;
   logic                   in_range;
   logic [AW-1:0]          tgt_base;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [RB-1:0]          ram_rd_data;
   logic [RB-1:0]          emit_req;

   genvar g;
   generate
      for (g = 0; g < MAX_WORKERS; g++) begin : g_mask
         if (g < MASK_W) begin : g_in
            assign mask_ext[g] = cap_mask_ff[g];
         end else begin : g_out
            assign mask_ext[g] = 1'b0;
         end
      end
   endgenerate

   assign w        = SW'(cap_slot_ff);
   assign in_range = int'(cap_slot_ff) < MAX_WORKERS;
   assign tgt      = (cap_op_ff == OP_ENQUEUE) ? hit_c_ff : w;
   assign scan_ent = order_ff[idx_ff[SW-1:0]];
   assign tgt_base = AW'(tgt) * AW'(QUEUE_DEPTH);

   always_comb begin
      stat.op            = cap_op_ff;
      stat.slot_in_range = in_range;
      stat.slot_act      = in_range && active_ff[w];
      stat.tgt_busy      = wbusy_ff[tgt];
      stat.tgt_empty     = (fill_ff[tgt] == '0);
      stat.tgt_full      = (fill_ff[tgt] == FW'(QUEUE_DEPTH));
      stat.scan_end      = (idx_ff >= count_ff);
      stat.scan_hit      = (cap_op_ff == OP_ENQUEUE) ? mask_ext[scan_ent]
                                                     : (scan_ent == w);
   end

   assign ram_wr_en   = cmd.enq_queue;
   assign ram_wr_addr = tgt_base + AW'(tail_ff[tgt]);
   assign ram_rd_en   = cmd.pop_issue;
   assign ram_rd_addr = tgt_base + AW'(head_ff[tgt]);

   lwdq_ram #(
      .WIDTH (RB),
      .DEPTH (RAM_DEPTH)
   ) u_pending (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (cap_req_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      cap_op_in     = cap_op_ff;
      cap_slot_in   = cap_slot_ff;
      cap_req_in    = cap_req_ff;
      cap_rvalid_in = cap_rvalid_ff;
      cap_mask_in   = cap_mask_ff;
      idx_in        = idx_ff;
      hit_c_in      = hit_c_ff;
      hit_pos_in    = hit_pos_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      order_in      = order_ff;
      active_in     = active_ff;
      wbusy_in      = wbusy_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;

      if (cmd.capture) begin
         cap_op_in     = req_opcode;
         cap_slot_in   = req_worker_slot;
         cap_req_in    = RB'(req_request_id);
         cap_rvalid_in = req_request_valid;
         cap_mask_in   = req_eligible_mask;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.hit_latch) begin
         hit_c_in   = scan_ent;
         hit_pos_in = idx_ff[SW-1:0];
      end

      // new worker goes to the front
      if (cmd.join_slot) begin
         for (int i = 1; i < MAX_WORKERS; i++) begin
            order_in[i] = order_ff[i-1];
         end
         order_in[0]  = w;
         count_in     = count_ff + CW'(1);
         active_in[w] = 1'b1;
         wbusy_in[w]  = cap_rvalid_ff;
         cur_in[w]    = cap_rvalid_ff ? cap_req_ff : '0;
         head_in[w]   = '0;
         tail_in[w]   = '0;
         fill_in[w]   = '0;
      end

      // winner moves to the back
      if (cmd.enq_assign || cmd.enq_queue) begin
         for (int i = 0; i < MAX_WORKERS - 1; i++) begin
            if (i >= int'(hit_pos_ff) && (i + 1) < int'(count_ff)) begin
               order_in[i] = order_ff[i+1];
            end
         end
         order_in[SW'(count_ff - CW'(1))] = hit_c_ff;
      end
      if (cmd.enq_assign) begin
         wbusy_in[tgt] = 1'b1;
         cur_in[tgt]   = cap_req_ff;
      end
      if (cmd.enq_queue) begin
         tail_in[tgt] = (tail_ff[tgt] == PW'(QUEUE_DEPTH - 1)) ? '0
                                                               : tail_ff[tgt] + PW'(1);
         fill_in[tgt] = fill_ff[tgt] + FW'(1);
         total_in     = total_ff + TW'(1);
      end

      // the whole backlog leaves at once in the count
      if (cmd.term_start) begin
         total_in = total_ff - TW'(fill_ff[w]);
      end
      if (cmd.term_close) begin
         for (int i = 0; i < MAX_WORKERS - 1; i++) begin
            if (i >= int'(hit_pos_ff)) begin
               order_in[i] = order_ff[i+1];
            end
         end
         count_in     = count_ff - CW'(1);
         active_in[w] = 1'b0;
         wbusy_in[w]  = 1'b0;
      end

      if (cmd.clear_busy) begin
         wbusy_in[w] = 1'b0;
      end
      if (cmd.pop_issue) begin
         head_in[w] = (head_ff[w] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff[w] + PW'(1);
         fill_in[w] = fill_ff[w] - FW'(1);
         if (cmd.pop_dec_total) begin
            total_in = total_ff - TW'(1);
         end
      end
      if (cmd.pop_to_current) begin
         cur_in[w]   = ram_rd_data;
         wbusy_in[w] = 1'b1;
      end
   end

   always_comb begin
      case (cmd.emit_src)
         SRC_REQ: emit_req = cap_req_ff;
         SRC_CUR: emit_req = cur_ff[w];
         SRC_RAM: emit_req = ram_rd_data;
         default: emit_req = '0;
      endcase
      strobe_in = cmd.emit;
      status_in = cmd.emit_status;
      ovalid_in = (cmd.emit_src != SRC_NONE);
      oreq_in   = REQ_W'(emit_req);
      last_in   = cmd.emit_last;
      qtot_in   = QTOT_W'(total_in);
      if (cap_op_ff == OP_ENQUEUE) begin
         chosen_in = (cmd.emit_src == SRC_NONE) ? '0 : SLOT_W'(hit_c_ff);
      end else begin
         chosen_in = cap_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < MAX_WORKERS; i++) begin
            active_ff[i] <= 1'b0;
            wbusy_ff[i]  <= 1'b0;
            head_ff[i]   <= '0;
            tail_ff[i]   <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         count_ff  <= count_in;
         total_ff  <= total_in;
         strobe_ff <= strobe_in;
         active_ff <= active_in;
         wbusy_ff  <= wbusy_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_op_ff     <= cap_op_in;
      cap_slot_ff   <= cap_slot_in;
      cap_req_ff    <= cap_req_in;
      cap_rvalid_ff <= cap_rvalid_in;
      cap_mask_ff   <= cap_mask_in;
      idx_ff        <= idx_in;
      hit_c_ff      <= hit_c_in;
      hit_pos_ff    <= hit_pos_in;
      order_ff      <= order_in;
      cur_ff        <= cur_in;
      if (cmd.emit) begin
         status_ff <= status_in;
         chosen_ff <= chosen_in;
         oreq_ff   <= oreq_in;
         ovalid_ff <= ovalid_in;
         last_ff   <= last_in;
         qtot_ff   <= qtot_in;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_chosen_worker = chosen_ff;
   assign rsp_out_request   = oreq_ff;
   assign rsp_out_valid     = ovalid_ff;
   assign rsp_last          = last_ff;
   assign rsp_queued_total  = qtot_ff;

endmodule

// ===== hw/rtl/lru_worker_dispatch_queues.sv =====
// Top level of the LRU worker dispatcher with per-worker request FIFOs.
// Depends on lwdq_pkg, lwdq_ctrl, lwdq_dpath (and lwdq_ram below it),
// and the assertion macro header.
`timescale 1ns / 1ps
`include "lru_worker_dispatch_queues_assert.svh"

// One command beat is taken at a clock edge where start is high and busy is
// low. Each result beat is shown for exactly one cycle with rsp_strobe high
// and cannot be held off: the consumer must take it then. A command gives one
// result beat (rsp_last set), except terminate, which gives the worker's
// current request, if it has one, then every queued request, one beat each,
// the last one marked (one empty beat if it has neither). Add, cancel, query
// and finished/assign on an empty FIFO go from dispatch straight back to
// idle; finished/assign with a queued request adds one pending-RAM read;
// enqueue scans the service list one entry per cycle up to the chosen
// worker, or to its end when no worker is eligible; terminate scans likewise,
// then takes one RAM read and one output beat per queued request. The result
// register sits between the engine and the result port, so busy falls in the
// cycle the final beat is shown.
module lru_worker_dispatch_queues
   import lwdq_pkg::*;
#(
   parameter int MAX_WORKERS     = LWDQ_MAX_WORKERS,
   parameter int QUEUE_DEPTH     = LWDQ_QUEUE_DEPTH,
   parameter int REQUEST_ID_BITS = LWDQ_REQUEST_ID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [SLOT_W-1:0] req_worker_slot,
   input  logic [REQ_W-1:0]  req_request_id,
   input  logic              req_request_valid,
   input  logic [MASK_W-1:0] req_eligible_mask,
   output logic              rsp_strobe,
   output logic [STAT_W-1:0] rsp_status,
   output logic [SLOT_W-1:0] rsp_chosen_worker,
   output logic [REQ_W-1:0]  rsp_out_request,
   output logic              rsp_out_valid,
   output logic              rsp_last,
   output logic [QTOT_W-1:0] rsp_queued_total
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // controller: sequences scan, pops and drain
   lwdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath: all worker state plus the result register
   lwdq_dpath #(
      .MAX_WORKERS     (MAX_WORKERS),
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .REQUEST_ID_BITS (REQUEST_ID_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_worker_slot   (req_worker_slot),
      .req_request_id    (req_request_id),
      .req_request_valid (req_request_valid),
      .req_eligible_mask (req_eligible_mask),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_chosen_worker (rsp_chosen_worker),
      .rsp_out_request   (rsp_out_request),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_last          (rsp_last),
      .rsp_queued_total  (rsp_queued_total)
   );

   // an accepted command always keeps the engine busy in the following cycle
   `LWDQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a beat without a request carries a zero request field
   `LWDQ_ASSERT_IMPL(a_empty_beat, clock, reset, rsp_strobe && !rsp_out_valid, rsp_out_request == '0)
   // only the drain of a terminate produces non-final beats
   `LWDQ_ASSERT_IMPL(a_single_last, clock, reset, rsp_strobe && rsp_status != ST_ASSIGNED, rsp_last)
   // no eligible worker reports slot zero and no request
   `LWDQ_ASSERT_IMPL(a_no_elig, clock, reset, rsp_strobe && rsp_status == ST_NO_ELIG, rsp_chosen_worker == '0 && !rsp_out_valid)

endmodule
